// ----- design/pnrd_pkg.sv -----
// Shared constants, types and a helper function of the packed note row decoder.
`timescale 1ns / 1ps

package pnrd_pkg;

   localparam int NUM_CHANNELS = 16;
   localparam int NUM_ROWS     = 64;

   localparam int CH_W  = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
   localparam int ROW_W = $clog2(NUM_ROWS);

   localparam int RSP_DATA_W = 56;

   localparam logic [3:0] SKIP_MASK = 4'h0f;

   typedef enum logic [2:0] {
      PH_HEADER,
      PH_NOTE,
      PH_INST,
      PH_VOL,
      PH_EFF_HI,
      PH_EFF_LO
   } phase_type;

   typedef struct packed {
      logic take;
      logic skip_row;
      logic note_row;
   } cmd_type;

   typedef struct packed {
      logic hdr_skip;
      logic out_free;
      logic row_end;
      logic cnt_one;
      logic mask_zero;
   } status_type;

   // First collected field after the given phase whose presence bit is set.
   function automatic phase_type next_phase(input logic [3:0] mask, input phase_type from);
      phase_type p;
      p = PH_HEADER;
      case (from)
         PH_HEADER: begin
            if (mask[0]) p = PH_NOTE;
            else if (mask[1]) p = PH_INST;
            else if (mask[2]) p = PH_VOL;
            else if (mask[3]) p = PH_EFF_HI;
         end
         PH_NOTE: begin
            if (mask[1]) p = PH_INST;
            else if (mask[2]) p = PH_VOL;
            else if (mask[3]) p = PH_EFF_HI;
         end
         PH_INST: begin
            if (mask[2]) p = PH_VOL;
            else if (mask[3]) p = PH_EFF_HI;
         end
         PH_VOL: begin
            if (mask[3]) p = PH_EFF_HI;
         end
         default: p = PH_HEADER;
      endcase
      return p;
   endfunction

endpackage

// ----- design/pnrd_ctrl.sv -----
// Controller state machine that sequences input acceptance and runs of empty rows.
`timescale 1ns / 1ps

module pnrd_ctrl
   import pnrd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_SKIP,
      S_ROW
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in     = state_ff;
      req_tready   = 1'b0;
      cmd.take     = 1'b0;
      cmd.skip_row = 1'b0;
      cmd.note_row = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_tready = status.out_free;
            cmd.take   = req_tvalid && status.out_free;
            if (cmd.take && status.hdr_skip) begin
               state_in = S_SKIP;
            end
         end
         S_SKIP: begin
            if (status.out_free) begin
               cmd.skip_row = 1'b1;
               if (status.row_end) begin
                  state_in = S_IDLE;
               end else if (status.cnt_one) begin
                  state_in = status.mask_zero ? S_ROW : S_IDLE;
               end
            end
         end
         S_ROW: begin
            if (status.out_free) begin
               cmd.note_row = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- design/pnrd_datapath.sv -----
// Datapath holding the row position, the collected fields and the result register.
`timescale 1ns / 1ps

module pnrd_datapath
   import pnrd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  cmd_type               cmd,
   output status_type            status,
   input  logic [7:0]            req_tdata,
   input  logic                  req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tuser,
   output logic                  rsp_tlast
);

   logic [CH_W-1:0]  chan_ff, chan_in;
   logic [ROW_W-1:0] row_ff, row_in;
   phase_type        phase_ff, phase_in;
   logic [3:0]       mask_ff, mask_in;
   logic [7:0]       note_ff, note_in;
   logic [7:0]       inst_ff, inst_in;
   logic [7:0]       vol_ff, vol_in;
   logic [15:0]      eff_ff, eff_in;
   logic [3:0]       cnt_ff, cnt_in;

   logic             ov_ff, ov_in;
   logic [3:0]       o_chan_ff, o_chan_in;
   logic [5:0]       o_row_ff, o_row_in;
   logic [3:0]       o_mask_ff, o_mask_in;
   logic [7:0]       o_note_ff, o_note_in;
   logic [7:0]       o_inst_ff, o_inst_in;
   logic [7:0]       o_vol_ff, o_vol_in;
   logic [15:0]      o_eff_ff, o_eff_in;
   logic             o_done_ff, o_done_in;
   logic             o_last_ff, o_last_in;

   logic             start;
   phase_type        eff_phase;
   phase_type        hdr_phase;
   phase_type        np;
   logic [CH_W-1:0]  pos_chan;
   logic [ROW_W-1:0] pos_row;
   logic             pos_end;
   logic [3:0]       base_mask;
   logic [7:0]       base_note;
   logic [7:0]       base_inst;
   logic [7:0]       base_vol;
   logic [15:0]      base_eff;
   logic [3:0]       skip;
   logic             emit;
   logic [3:0]       e_mask;
   logic [7:0]       e_note;
   logic [7:0]       e_inst;
   logic [7:0]       e_vol;
   logic [15:0]      e_eff;
   logic             e_last;
   logic             clear;

   assign start     = cmd.take && req_tuser;
   assign eff_phase = start ? PH_HEADER : phase_ff;
   assign hdr_phase = req_tuser ? PH_HEADER : phase_ff;
   assign pos_chan  = start ? '0 : chan_ff;
   assign pos_row   = start ? '0 : row_ff;
   assign pos_end   = (pos_row == ROW_W'(NUM_ROWS - 1));
   assign base_mask = start ? 4'h0 : mask_ff;
   assign base_note = start ? 8'h00 : note_ff;
   assign base_inst = start ? 8'h00 : inst_ff;
   assign base_vol  = start ? 8'h00 : vol_ff;
   assign base_eff  = start ? 16'h0000 : eff_ff;
   assign skip      = req_tdata[3:0] & SKIP_MASK;

   assign status.out_free  = !ov_ff || rsp_tready;
   assign status.hdr_skip  = (hdr_phase != PH_NOTE) && (hdr_phase != PH_INST)
                          && (hdr_phase != PH_VOL) && (hdr_phase != PH_EFF_HI)
                          && (hdr_phase != PH_EFF_LO) && (skip != 4'h0);
   assign status.row_end   = (row_ff == ROW_W'(NUM_ROWS - 1));
   assign status.cnt_one   = (cnt_ff == 4'h1);
   assign status.mask_zero = (mask_ff == 4'h0);

   always_comb begin
      phase_in = phase_ff;
      mask_in  = mask_ff;
      note_in  = note_ff;
      inst_in  = inst_ff;
      vol_in   = vol_ff;
      eff_in   = eff_ff;
      cnt_in   = cnt_ff;
      emit     = 1'b0;
      e_mask   = 4'h0;
      e_note   = 8'h00;
      e_inst   = 8'h00;
      e_vol    = 8'h00;
      e_eff    = 16'h0000;
      e_last   = 1'b1;
      clear    = 1'b0;
      np       = PH_HEADER;

      if (cmd.take) begin
         mask_in = base_mask;
         note_in = base_note;
         inst_in = base_inst;
         vol_in  = base_vol;
         eff_in  = base_eff;
         case (eff_phase)
            PH_NOTE: begin
               note_in = req_tdata;
               np      = next_phase(base_mask, PH_NOTE);
            end
            PH_INST: begin
               inst_in = req_tdata;
               np      = next_phase(base_mask, PH_INST);
            end
            PH_VOL: begin
               vol_in = req_tdata;
               np     = next_phase(base_mask, PH_VOL);
            end
            PH_EFF_HI: begin
               eff_in = {req_tdata, 8'h00};
               np     = PH_EFF_LO;
            end
            PH_EFF_LO: begin
               eff_in = {base_eff[15:8], req_tdata};
               np     = PH_HEADER;
            end
            default: begin
               note_in = 8'h00;
               inst_in = 8'h00;
               vol_in  = 8'h00;
               eff_in  = 16'h0000;
               mask_in = req_tdata[7:4];
               cnt_in  = skip;
               np      = (skip != 4'h0) ? PH_HEADER : next_phase(req_tdata[7:4], PH_HEADER);
            end
         endcase
         phase_in = np;
         if (np == PH_HEADER && !status.hdr_skip) begin
            emit   = 1'b1;
            e_mask = mask_in;
            e_note = note_in;
            e_inst = inst_in;
            e_vol  = vol_in;
            e_eff  = eff_in;
            clear  = 1'b1;
         end
      end else if (cmd.skip_row) begin
         emit   = 1'b1;
         e_last = status.row_end || (status.cnt_one && !status.mask_zero);
         cnt_in = cnt_ff - 4'h1;
         if (status.row_end) begin
            clear = 1'b1;
         end else if (status.cnt_one && !status.mask_zero) begin
            phase_in = next_phase(mask_ff, PH_HEADER);
         end
      end else if (cmd.note_row) begin
         emit   = 1'b1;
         e_mask = mask_ff;
         e_note = note_ff;
         e_inst = inst_ff;
         e_vol  = vol_ff;
         e_eff  = eff_ff;
         clear  = 1'b1;
      end

      if (clear) begin
         phase_in = PH_HEADER;
         mask_in  = 4'h0;
         note_in  = 8'h00;
         inst_in  = 8'h00;
         vol_in   = 8'h00;
         eff_in   = 16'h0000;
      end
   end

   always_comb begin
      chan_in   = pos_chan;
      row_in    = pos_row;
      ov_in     = ov_ff && !rsp_tready;
      o_chan_in = o_chan_ff;
      o_row_in  = o_row_ff;
      o_mask_in = o_mask_ff;
      o_note_in = o_note_ff;
      o_inst_in = o_inst_ff;
      o_vol_in  = o_vol_ff;
      o_eff_in  = o_eff_ff;
      o_done_in = o_done_ff;
      o_last_in = o_last_ff;
      if (emit) begin
         ov_in     = 1'b1;
         o_chan_in = 4'(pos_chan);
         o_row_in  = 6'(pos_row);
         o_mask_in = e_mask;
         o_note_in = e_note;
         o_inst_in = e_inst;
         o_vol_in  = e_vol;
         o_eff_in  = e_eff;
         o_done_in = pos_end && (pos_chan == CH_W'(NUM_CHANNELS - 1));
         o_last_in = e_last;
         if (pos_end) begin
            row_in  = '0;
            chan_in = (pos_chan == CH_W'(NUM_CHANNELS - 1)) ? '0 : pos_chan + 1'b1;
         end else begin
            row_in = pos_row + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chan_ff  <= '0;
         row_ff   <= '0;
         phase_ff <= PH_HEADER;
         mask_ff  <= 4'h0;
         note_ff  <= 8'h00;
         inst_ff  <= 8'h00;
         vol_ff   <= 8'h00;
         eff_ff   <= 16'h0000;
         cnt_ff   <= 4'h0;
         ov_ff    <= 1'b0;
      end else begin
         chan_ff  <= chan_in;
         row_ff   <= row_in;
         phase_ff <= phase_in;
         mask_ff  <= mask_in;
         note_ff  <= note_in;
         inst_ff  <= inst_in;
         vol_ff   <= vol_in;
         eff_ff   <= eff_in;
         cnt_ff   <= cnt_in;
         ov_ff    <= ov_in;
      end
   end

   always_ff @(posedge clock) begin
      o_chan_ff <= o_chan_in;
      o_row_ff  <= o_row_in;
      o_mask_ff <= o_mask_in;
      o_note_ff <= o_note_in;
      o_inst_ff <= o_inst_in;
      o_vol_ff  <= o_vol_in;
      o_eff_ff  <= o_eff_in;
      o_done_ff <= o_done_in;
      o_last_ff <= o_last_in;
   end

   assign rsp_tvalid = ov_ff;
   assign rsp_tdata  = {2'b00, o_eff_ff, o_vol_ff, o_inst_ff, o_note_ff,
                        o_mask_ff, o_row_ff, o_chan_ff};
   assign rsp_tuser  = o_done_ff;
   assign rsp_tlast  = o_last_ff;

endmodule

// ----- design/packed_note_row_decoder.sv -----
// Top level of the packed note row decoder: controller plus datapath.
`timescale 1ns / 1ps

// The req channel takes one word per byte of the packed pattern stream; tuser set
// on a word returns the decoder to channel 0 row 0 before that byte is handled.
// The rsp channel delivers one word per note row; tlast marks the final row
// caused by an input byte and tuser marks the last row of the last channel.
// A payload byte that completes a row, or a header without skip and without
// payload, is taken and its row appears in the output register on the next
// cycle. Other payload bytes produce no word.
// A header with a skip count of s is accepted, after which the controller emits
// the s empty rows one per cycle while the output register is free, plus the
// header's own empty row when it has no payload; input is held off while the
// run is emitted. The run stops early at the end of a channel.
// A single output register separates the channels: while a word waits, the next
// byte is still taken if the receiver takes that word in the same cycle, and a
// stall on rsp holds the word and stops all further progress.
// Reset clears the position, the collected fields and the output valid flag; the output data is not reset.

module packed_note_row_decoder
   import pnrd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            req_tdata,  // byte_value
   input  logic                  req_tuser,  // pattern_start
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,  // channel, row, present_mask, note_value,
                                             // instrument, volume, effect, zero pad
   output logic                  rsp_tuser,  // pattern_done
   output logic                  rsp_tlast   // last_of_run
);

   cmd_type    cmd;
   status_type status;

   pnrd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   pnrd_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
